### rtl/core/fmbq_pkg.sv
// fmbq_pkg: types and constants for the front/middle/back queue
// used by fmbq_cell and front_middle_back_queue; no dependencies
`timescale 1ns / 1ps

package fmbq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT  = 3'd0,
		REQ_PUSH_MIDDLE = 3'd1,
		REQ_PUSH_BACK   = 3'd2,
		REQ_POP_FRONT   = 3'd3,
		REQ_POP_MIDDLE  = 3'd4,
		REQ_POP_BACK    = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_code_t;

	localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

	typedef struct packed {
		logic [2:0]              req_type;
		logic signed [VAL_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] pop_value;
	} rsp_t;

	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic [IDX_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} cell_op_t;

endpackage

### rtl/core/front_middle_back_queue.sv
// front_middle_back_queue: top level of the bounded front/middle/back queue
// instantiates a row of fmbq_cell; depends on fmbq_pkg
`timescale 1ns / 1ps

// A request is taken and its result is registered for the next cycle:
// one transfer per clock while the result side keeps up. The queue is a row of
// DEPTH cells; every cell compares its own index against the insert or remove
// position and in the same cycle shifts from a neighbour or loads the pushed
// value, so the cost of a request does not depend on where it lands. A middle
// push inserts at floor(count/2), a middle pop removes floor((count-1)/2).
// Popping an empty queue returns status 1 and -1; pushing a full queue is
// dropped with status 2 and -1. No clearing pass is needed after reset.

module front_middle_back_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fmbq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fmbq_pkg::rsp_t  rsp
);

	logic [fmbq_pkg::CNT_W-1:0]        count_q;
	logic [fmbq_pkg::CNT_W-1:0]        count_d;
	logic                              rsp_valid_q;
	fmbq_pkg::rsp_t                    rsp_q;
	fmbq_pkg::rsp_t                    rsp_d;
	fmbq_pkg::cell_op_t                op;
	logic [fmbq_pkg::CNT_W-1:0]        pos_wide;
	logic                              take;
	logic                              is_full;
	logic                              is_empty;
	logic signed [fmbq_pkg::VAL_W-1:0] cell_val [fmbq_pkg::DEPTH];
	logic signed [fmbq_pkg::VAL_W-1:0] cell_hit [fmbq_pkg::DEPTH];
	logic signed [fmbq_pkg::VAL_W-1:0] read_val;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign is_full   = (count_q == fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH));
	assign is_empty  = (count_q == '0);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		read_val = '0;
		for (int i = 0; i < fmbq_pkg::DEPTH; i++) begin
			read_val = read_val | cell_hit[i];
		end
	end

	always_comb begin
		op.ins           = 1'b0;
		op.rem           = 1'b0;
		op.value         = req.push_value;
		pos_wide         = '0;
		count_d          = count_q;
		rsp_d.status     = fmbq_pkg::ST_DONE;
		rsp_d.pop_value  = fmbq_pkg::NO_VALUE;
		unique case (req.req_type) inside
			fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MIDDLE,
			fmbq_pkg::REQ_PUSH_BACK: begin
				if (is_full) begin
					rsp_d.status = fmbq_pkg::ST_FULL;
				end else begin
					op.ins  = take;
					count_d = count_q + 1'b1;
					if (req.req_type == fmbq_pkg::REQ_PUSH_MIDDLE) begin
						pos_wide = count_q >> 1;
					end else if (req.req_type == fmbq_pkg::REQ_PUSH_BACK) begin
						pos_wide = count_q;
					end
				end
			end
			fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MIDDLE,
			fmbq_pkg::REQ_POP_BACK: begin
				if (is_empty) begin
					rsp_d.status = fmbq_pkg::ST_EMPTY;
				end else begin
					op.rem  = take;
					count_d = count_q - 1'b1;
					if (req.req_type == fmbq_pkg::REQ_POP_MIDDLE) begin
						pos_wide = (count_q - 1'b1) >> 1;
					end else if (req.req_type == fmbq_pkg::REQ_POP_BACK) begin
						pos_wide = count_q - 1'b1;
					end
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
		op.pos = pos_wide[fmbq_pkg::IDX_W-1:0];
		if (op.rem || (!op.ins && count_d != count_q)) begin
			rsp_d.pop_value = read_val;
		end
	end

	generate
		for (genvar i = 0; i < fmbq_pkg::DEPTH; i++) begin : g_cell
			logic signed [fmbq_pkg::VAL_W-1:0] left_v;
			logic signed [fmbq_pkg::VAL_W-1:0] right_v;
			if (i == 0) begin : g_first
				assign left_v = req.push_value;
			end else begin : g_mid_l
				assign left_v = cell_val[i-1];
			end
			if (i == fmbq_pkg::DEPTH - 1) begin : g_last
				assign right_v = cell_val[i];
			end else begin : g_mid_r
				assign right_v = cell_val[i+1];
			end
			fmbq_cell u_cell (
				.clk   (clk),
				.idx   (fmbq_pkg::IDX_W'(i)),
				.op    (op),
				.left  (left_v),
				.right (right_v),
				.value (cell_val[i]),
				.hit   (cell_hit[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

### rtl/core/fmbq_cell.sv
// fmbq_cell: one storage cell of the queue chain
// shifts from either neighbour or loads a new value; depends on fmbq_pkg
`timescale 1ns / 1ps

module fmbq_cell (
	input  logic                                    clk,
	input  logic [fmbq_pkg::IDX_W-1:0]              idx,
	input  fmbq_pkg::cell_op_t                      op,
	input  logic signed [fmbq_pkg::VAL_W-1:0]       left,
	input  logic signed [fmbq_pkg::VAL_W-1:0]       right,
	output logic signed [fmbq_pkg::VAL_W-1:0]       value,
	output logic signed [fmbq_pkg::VAL_W-1:0]       hit
);

	logic signed [fmbq_pkg::VAL_W-1:0] value_q;
	logic                              at_pos;
	logic                              past_pos;

	assign at_pos   = (idx == op.pos);
	assign past_pos = (idx > op.pos);
	assign value    = value_q;
	assign hit      = at_pos ? value_q : '0;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (past_pos) begin
				value_q <= left;
			end else if (at_pos) begin
				value_q <= op.value;
			end
		end else if (op.rem) begin
			if (past_pos || at_pos) begin
				value_q <= right;
			end
		end
	end

endmodule

### verif/testbench.sv
// testbench: self-checking test of front_middle_back_queue with its own queue predictor
// drives requests in bursts with random receiver stalls; depends on fmbq_pkg
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 390;
	localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
	localparam logic signed [fmbq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [fmbq_pkg::VAL_W-1:0] VAL_MIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fmbq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fmbq_pkg::rsp_t rsp;

	logic signed [fmbq_pkg::VAL_W-1:0] queue_model[$];
	fmbq_pkg::rsp_t expected_rsp[$];
	int errors = 0;
	int cycle_count = 0;
	int burst_left = 4;
	bit no_gaps = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_mode = 0;

	front_middle_back_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// queue predictor: applies one request to the model and gives its result
	function automatic fmbq_pkg::rsp_t apply_request(input fmbq_pkg::req_t item);
		fmbq_pkg::rsp_t res;
		int unsigned count;
		res.status = fmbq_pkg::ST_DONE;
		res.pop_value = fmbq_pkg::NO_VALUE;
		count = queue_model.size();
		case (item.req_type) inside
			fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MIDDLE,
			fmbq_pkg::REQ_PUSH_BACK: begin
				if (count >= fmbq_pkg::DEPTH) begin
					res.status = fmbq_pkg::ST_FULL;
				end else if (item.req_type == fmbq_pkg::REQ_PUSH_FRONT) begin
					queue_model.push_front(item.push_value);
				end else if (item.req_type == fmbq_pkg::REQ_PUSH_MIDDLE) begin
					queue_model.insert(count / 2, item.push_value);
				end else begin
					queue_model.push_back(item.push_value);
				end
			end
			fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MIDDLE,
			fmbq_pkg::REQ_POP_BACK: begin
				if (count == 0) begin
					res.status = fmbq_pkg::ST_EMPTY;
				end else if (item.req_type == fmbq_pkg::REQ_POP_FRONT) begin
					res.pop_value = queue_model.pop_front();
				end else if (item.req_type == fmbq_pkg::REQ_POP_MIDDLE) begin
					res.pop_value = queue_model[(count - 1) / 2];
					queue_model.delete((count - 1) / 2);
				end else begin
					res.pop_value = queue_model.pop_back();
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic send_req(input logic [2:0] code,
		input logic signed [fmbq_pkg::VAL_W-1:0] value);
		fmbq_pkg::req_t item;
		item.req_type = code;
		item.push_value = value;
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(apply_request(item));
		burst_left--;
		if (burst_left <= 0 && !no_gaps) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic logic signed [fmbq_pkg::VAL_W-1:0] random_value();
		case ($urandom_range(0, 15))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return fmbq_pkg::NO_VALUE;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic test_empty_pops();
		send_req(fmbq_pkg::REQ_POP_FRONT, VAL_MAX);
		send_req(fmbq_pkg::REQ_POP_MIDDLE, VAL_MIN);
		send_req(fmbq_pkg::REQ_POP_BACK, '0);
		send_req(REQ_UNUSED_LO, 32'sh12345678);
		send_req(REQ_UNUSED_HI, fmbq_pkg::NO_VALUE);
	endtask

	task automatic test_fill_and_overflow();
		logic signed [fmbq_pkg::VAL_W-1:0] extremes[4];
		extremes = '{VAL_MAX, VAL_MIN, '0, fmbq_pkg::NO_VALUE};
		for (int i = 0; i < fmbq_pkg::DEPTH; i++) begin
			send_req(fmbq_pkg::req_code_t'(i % 3), (i < 4) ? extremes[i] : random_value());
		end
		send_req(fmbq_pkg::REQ_PUSH_FRONT, VAL_MAX);
		send_req(fmbq_pkg::REQ_PUSH_MIDDLE, VAL_MIN);
		send_req(fmbq_pkg::REQ_PUSH_BACK, fmbq_pkg::NO_VALUE);
		send_req(fmbq_pkg::REQ_POP_MIDDLE, '0);
		send_req(fmbq_pkg::REQ_POP_FRONT, '0);
		send_req(fmbq_pkg::REQ_POP_BACK, '0);
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_request = 80;
		for (int i = 0; i < 30; i++) begin
			send_req(fmbq_pkg::req_code_t'($urandom_range(0, 5)), random_value());
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random_mix();
		int sent;
		int push_pct;
		logic [2:0] code;
		sent = 0;
		push_pct = 50;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 15;
				endcase
			end
			if ($urandom_range(0, 99) < 3) begin
				code = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
			end else begin
				if ($urandom_range(0, 99) < push_pct) begin
					code = 3'($urandom_range(fmbq_pkg::REQ_PUSH_FRONT,
						fmbq_pkg::REQ_PUSH_BACK));
				end else begin
					code = 3'($urandom_range(fmbq_pkg::REQ_POP_FRONT,
						fmbq_pkg::REQ_POP_BACK));
				end
				sent++;
			end
			send_req(code, random_value());
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin : rsp_side
		fmbq_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected transfer: status %0d pop_value %0d", rsp.status,
					rsp.pop_value);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.pop_value !== want.pop_value) begin
					$error("pop_value: expected %0d, actual %0d", want.pop_value,
						rsp.pop_value);
					errors++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (cycle_count % 50 == 0) begin
			stall_mode = $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 9) < 7);
				default: rsp_stall <= cycle_count[1];
			endcase
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pops();
		test_fill_and_overflow();
		test_backpressure();
		test_random_mix();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
